// ===== hdl/iplpm_pkg.sv =====
// Package for the IPv4 longest-prefix-match table: sizes, codes, item types.
`timescale 1ns / 1ps

package iplpm_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int ADDR_W        = 32;
  localparam int LEN_W         = 6;
  localparam int MAX_LEN       = 32;

  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_DEL   = 2'd1;
  localparam logic [1:0] ACT_CHECK = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_LEN   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [1:0]        action;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  prefix_len;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             match_found;
    logic [LEN_W-1:0] match_len;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [LEN_W-1:0]  len;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Network mask for a prefix length; zero length covers everything.
  function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    logic [ADDR_W-1:0] m;
    begin
      if (len == '0) begin
        m = '0;
      end else if (len >= LEN_W'(MAX_LEN)) begin
        m = '1;
      end else begin
        m = {ADDR_W{1'b1}} << (LEN_W'(MAX_LEN) - len);
      end
      return m;
    end
  endfunction

endpackage

// ===== hdl/iplpm_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module iplpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/ipv4_prefix_table_longest_match.sv =====
// IPv4 prefix table with add, delete and longest-prefix check.
// An item with a bad length, an unused action or an empty table goes straight to its result;
// otherwise it first scans the stored entries (up to TABLE_ENTRIES of them).
// One item at a time; each stored entry passes the single RAM read port and the shared
// mask/compare unit at most once; a delete streams the later entries down the same port.
// Reset clears the entry count, sequencer and output valid; the RAM is not cleared.
`timescale 1ns / 1ps

module ipv4_prefix_table_longest_match (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  iplpm_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output iplpm_pkg::out_item_t out_item_o
);

  import iplpm_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] issue_q, issue_d;
  logic [CNT_W-1:0] rd_idx_q, rd_idx_d;
  logic             rd_vld_q, rd_vld_d;
  in_item_t         op_q, op_d;
  out_item_t        res_q, res_d;
  logic             out_valid_q;
  out_item_t        out_q;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  entry_t           rd_data;
  logic             issue;
  logic             in_acc;
  logic             out_free;
  logic             rd_last;
  logic             exact;
  logic             covered;
  logic [ADDR_W-1:0] mask;

  iplpm_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .raddr_i(issue_q[IDX_W-1:0]),
    .rdata_o(rd_data)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Shared compare unit on the entry coming out of the RAM
  assign rd_last = ((rd_idx_q + CNT_W'(1)) == count_q);
  assign mask    = len_mask(rd_data.len);
  assign exact   = (rd_data.base == op_q.address) && (rd_data.len == op_q.prefix_len);
  assign covered = ((rd_data.base & mask) == (op_q.address & mask));

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    issue_d  = issue_q;
    rd_idx_d = rd_idx_q;
    rd_vld_d = 1'b0;
    op_d     = op_q;
    res_d    = res_q;
    wr_en    = 1'b0;
    wr_addr  = count_q[IDX_W-1:0];
    wr_data  = '{base: op_q.address, len: op_q.prefix_len};
    issue    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d    = in_item_i;
          res_d   = '0;
          issue_d = '0;
          state_d = S_DONE;
          unique case (in_item_i.action)
            ACT_ADD, ACT_DEL: begin
              if (in_item_i.prefix_len > LEN_W'(MAX_LEN)) begin
                res_d.status = ST_BAD_LEN;
              end else if (count_q == '0) begin
                if (in_item_i.action == ACT_ADD) begin
                  wr_en   = 1'b1;
                  wr_addr = '0;
                  wr_data = '{base: in_item_i.address, len: in_item_i.prefix_len};
                  count_d = CNT_W'(1);
                end else begin
                  res_d.status = ST_NOT_FOUND;
                end
              end else begin
                state_d = S_SCAN;
              end
            end
            ACT_CHECK: begin
              if (count_q != '0) begin
                state_d = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        issue    = (issue_q < count_q);
        issue_d  = issue ? issue_q + CNT_W'(1) : issue_q;
        rd_vld_d = issue;
        rd_idx_d = issue_q;
        if (rd_vld_q) begin
          unique case (op_q.action)
            ACT_ADD: begin
              if (exact) begin
                state_d  = S_DONE;
                rd_vld_d = 1'b0;
              end else if (rd_last) begin
                if (count_q == CNT_W'(TABLE_ENTRIES)) begin
                  res_d.status = ST_FULL;
                end else begin
                  wr_en   = 1'b1;
                  count_d = count_q + CNT_W'(1);
                end
                state_d  = S_DONE;
                rd_vld_d = 1'b0;
              end
            end
            ACT_DEL: begin
              if (exact) begin
                if (rd_last) begin
                  count_d  = count_q - CNT_W'(1);
                  state_d  = S_DONE;
                  rd_vld_d = 1'b0;
                end else begin
                  // next entry is already in flight; keep streaming
                  state_d = S_SHIFT;
                end
              end else if (rd_last) begin
                res_d.status = ST_NOT_FOUND;
                state_d      = S_DONE;
                rd_vld_d     = 1'b0;
              end
            end
            default: begin
              if (covered) begin
                if (!res_q.match_found || (rd_data.len > res_q.match_len)) begin
                  res_d.match_len = rd_data.len;
                end
                res_d.match_found = 1'b1;
              end
              if (rd_last) begin
                state_d  = S_DONE;
                rd_vld_d = 1'b0;
              end
            end
          endcase
        end
      end

      S_SHIFT: begin
        issue    = (issue_q < count_q);
        issue_d  = issue ? issue_q + CNT_W'(1) : issue_q;
        rd_vld_d = issue;
        rd_idx_d = issue_q;
        if (rd_vld_q) begin
          wr_en   = 1'b1;
          wr_addr = IDX_W'(rd_idx_q - CNT_W'(1));
          wr_data = rd_data;
          if (rd_last) begin
            count_d  = count_q - CNT_W'(1);
            state_d  = S_DONE;
            rd_vld_d = 1'b0;
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      issue_q     <= '0;
      rd_idx_q    <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      issue_q  <= issue_d;
      rd_idx_q <= rd_idx_d;
      rd_vld_q <= rd_vld_d;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    res_q <= res_d;
    if (state_q == S_DONE && out_free) begin
      out_q <= res_q;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_ENTRIES))
    else $error("entry count above table size");

  a_rd_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == S_SCAN || state_q == S_SHIFT))
    else $error("entry read pending outside scan");

  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> ({1'b0, wr_addr} <= count_q))
    else $error("write beyond stored entries");

  a_err_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != ST_OK) |-> (!out_q.match_found && out_q.match_len == '0))
    else $error("match fields set on error result");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !in_acc) |=> $stable(count_q))
    else $error("entry count changed without an item");

endmodule

// ===== sim/tb_ipv4_prefix_table_longest_match.sv =====
// Self-checking testbench for the IPv4 longest-prefix-match table.
`timescale 1ns / 1ps

module tb_ipv4_prefix_table_longest_match;
  import iplpm_pkg::*;

  // Action code the block ignores.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      out_stall_i = 1'b0;
  in_item_t  in_item_i   = '0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_item_o;

  ipv4_prefix_table_longest_match dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow copy of the prefix table.
  logic [ADDR_W-1:0] tbl_base [TABLE_ENTRIES];
  logic [LEN_W-1:0]  tbl_len  [TABLE_ENTRIES];
  int                tbl_count;

  out_item_t pending_results[$];

  bit idle_on;
  int stall_left;
  int error_cnt, mismatch_cnt;
  int n_add, n_del, n_check, n_ignored, n_hits, n_full, n_bad_len, n_missing, n_dup;

  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    // shift of 32 gives zero, so length 32 is all ones and 0 is none
    return ~(32'hFFFF_FFFF >> len);
  endfunction

  function automatic int find_prefix(input logic [ADDR_W-1:0] base,
                                     input logic [LEN_W-1:0] len);
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_base[i] == base && tbl_len[i] == len) return i;
    end
    return -1;
  endfunction

  // Computes the result of one item and applies it to the shadow table.
  function automatic out_item_t lpm_predict(input in_item_t it);
    out_item_t r;
    int pos;
    logic [ADDR_W-1:0] m;
    r = '0;
    pos = find_prefix(it.address, it.prefix_len);
    case (it.action)
      ACT_ADD: begin
        if (it.prefix_len > MAX_LEN) begin
          r.status = ST_BAD_LEN;
        end else if (pos >= 0) begin
          n_dup++;  // already stored, ok even when full
        end else if (tbl_count == TABLE_ENTRIES) begin
          r.status = ST_FULL;
        end else begin
          tbl_base[tbl_count] = it.address;
          tbl_len[tbl_count]  = it.prefix_len;
          tbl_count++;
        end
      end
      ACT_DEL: begin
        if (it.prefix_len > MAX_LEN) begin
          r.status = ST_BAD_LEN;
        end else if (pos < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          for (int i = pos; i + 1 < tbl_count; i++) begin
            tbl_base[i] = tbl_base[i+1];
            tbl_len[i]  = tbl_len[i+1];
          end
          tbl_count--;
        end
      end
      ACT_CHECK: begin
        for (int i = 0; i < tbl_count; i++) begin
          m = prefix_mask(tbl_len[i]);
          if ((tbl_base[i] & m) == (it.address & m)) begin
            if (!r.match_found || tbl_len[i] > r.match_len) r.match_len = tbl_len[i];
            r.match_found = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Address inside the prefix stored at idx, random host bits.
  function automatic logic [ADDR_W-1:0] near_address(input int idx);
    logic [ADDR_W-1:0] m;
    m = prefix_mask(tbl_len[idx]);
    return (tbl_base[idx] & m) | ($urandom & ~m);
  endfunction

  task automatic send_item(input logic [1:0] act, input logic [ADDR_W-1:0] addr,
                           input logic [LEN_W-1:0] plen);
    in_item_t  it;
    out_item_t res;
    it.action     = act;
    it.address    = addr;
    it.prefix_len = plen;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    res = lpm_predict(it);
    pending_results.push_back(res);
    case (act)
      ACT_ADD:   n_add++;
      ACT_DEL:   n_del++;
      ACT_CHECK: n_check++;
      default:   n_ignored++;
    endcase
    if (res.match_found) n_hits++;
    if (res.status == ST_FULL) n_full++;
    if (res.status == ST_BAD_LEN) n_bad_len++;
    if (res.status == ST_NOT_FOUND) n_missing++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic void report_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      error_cnt++;
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endfunction

  // Result checker and random output stall.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          error_cnt++;
          $display("%0t: result with no item outstanding", $time);
        end else begin
          out_item_t exp_r;
          exp_r = pending_results.pop_front();
          report_field("status", exp_r.status, out_item_o.status);
          report_field("match_found", exp_r.match_found, out_item_o.match_found);
          report_field("match_len", exp_r.match_len, out_item_o.match_len);
        end
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        stall_left = $urandom_range(0, 4);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic test_directed();
    send_item(ACT_CHECK, 32'h0A00_0001, 6'd0);      // empty table
    send_item(ACT_ADD,   32'h0A00_0000, 6'd8);
    send_item(ACT_ADD,   32'h0A01_0000, 6'd16);
    send_item(ACT_CHECK, 32'h0A01_0203, 6'd0);
    send_item(ACT_CHECK, 32'h0AFF_0000, 6'd0);
    send_item(ACT_ADD,   32'h1234_5678, 6'd0);      // default route
    send_item(ACT_CHECK, 32'hC0A8_0001, 6'd0);
    send_item(ACT_ADD,   32'hFFFF_FFFF, 6'd32);
    send_item(ACT_CHECK, 32'hFFFF_FFFF, 6'd63);     // len ignored on check
    send_item(ACT_ADD,   32'h0A00_0000, 6'd8);      // duplicate
    send_item(ACT_ADD,   32'h0A00_00FF, 6'd8);      // same net, other host bits
    send_item(ACT_ADD,   32'h0A00_0000, 6'd33);
    send_item(ACT_ADD,   32'hFFFF_FFFF, 6'd63);
    send_item(ACT_DEL,   32'h0A00_0000, 6'd40);
    send_item(ACT_DEL,   32'h0A00_0000, 6'd9);      // not stored
    send_item(ACT_DEL,   32'h0A00_0000, 6'd8);
    send_item(ACT_CHECK, 32'h0A00_00AA, 6'd0);
    send_item(ACT_DEL,   32'h1234_5678, 6'd0);
    send_item(ACT_CHECK, 32'h0102_0304, 6'd0);
    send_item(ACT_UNUSED, 32'hFFFF_FFFF, 6'd63);
    send_item(ACT_ADD,   32'h8000_0000, 6'd1);
    send_item(ACT_CHECK, 32'h7FFF_FFFF, 6'd0);
    send_item(ACT_DEL,   32'hFFFF_FFFF, 6'd32);
    send_item(ACT_ADD,   32'h0000_0000, 6'd32);
    send_item(ACT_CHECK, 32'h0000_0000, 6'd0);
  endtask

  task automatic test_full_table();
    int i;
    i = 0;
    while (tbl_count < TABLE_ENTRIES) begin
      send_item(ACT_ADD, 32'hC000_0000 | i, 6'd32);
      i++;
    end
    send_item(ACT_ADD, 32'hDEAD_BEEF, 6'd24);      // rejected, full
    send_item(ACT_ADD, tbl_base[5], tbl_len[5]);   // duplicate while full
    send_item(ACT_DEL, 32'hDEAD_BEEF, 6'd24);
    send_item(ACT_CHECK, 32'hC000_0003, 6'd0);
    send_item(ACT_DEL, tbl_base[0], tbl_len[0]);
    send_item(ACT_DEL, tbl_base[tbl_count-1], tbl_len[tbl_count-1]);
    send_item(ACT_DEL, tbl_base[tbl_count/2], tbl_len[tbl_count/2]);
    send_item(ACT_ADD, 32'hDEAD_BEEF, 6'd24);
    send_item(ACT_CHECK, 32'hDEAD_BE00, 6'd0);
    while (tbl_count > 20) send_item(ACT_DEL, tbl_base[0], tbl_len[0]);
  endtask

  task automatic test_random_traffic(input int n_items);
    int k, r, sub, idx, w_add, w_del;
    logic [1:0]        act;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  plen;
    for (k = 0; k < n_items; k++) begin
      // alternate growing and shrinking so the table swings between empty and full
      w_add = ((k / 150) % 2 == 0) ? 55 : 20;
      w_del = ((k / 150) % 2 == 0) ? 15 : 45;
      r   = $urandom_range(0, 99);
      sub = $urandom_range(0, 9);
      idx = (tbl_count > 0) ? $urandom_range(0, tbl_count - 1) : 0;
      addr = $urandom;
      plen = LEN_W'($urandom_range(0, MAX_LEN));
      if (r < 6) begin
        act  = 2'($urandom);
        plen = LEN_W'($urandom);
      end else if (r < 6 + w_add) begin
        act = ACT_ADD;
        if (sub == 0 && tbl_count > 0) begin
          addr = tbl_base[idx];
          plen = tbl_len[idx];
        end else if (sub == 1 && tbl_count > 0) begin
          addr = near_address(idx);
          plen = tbl_len[idx];
        end else if (sub == 2) begin
          plen = LEN_W'($urandom_range(MAX_LEN + 1, 63));
        end
      end else if (r < 6 + w_add + w_del) begin
        act = ACT_DEL;
        if (sub < 7 && tbl_count > 0) begin
          addr = tbl_base[idx];
          plen = tbl_len[idx];
        end else if (sub == 7) begin
          plen = LEN_W'($urandom_range(MAX_LEN + 1, 63));
        end else if (sub == 8 && tbl_count > 0) begin
          addr = near_address(idx);
          plen = tbl_len[idx];
        end
      end else begin
        act  = ACT_CHECK;
        plen = LEN_W'($urandom);
        if (sub < 8 && tbl_count > 0) addr = near_address(idx);
      end
      send_item(act, addr, plen);
    end
  endtask

  initial begin
    idle_on = 1'b1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_table();
    test_random_traffic(700);
    wait_drained();
    test_random_traffic(450);
    idle_on = 1'b0;
    stall_left = 0;
    test_random_traffic(250);
    wait_drained();
    repeat (2 * TABLE_ENTRIES + 10) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      error_cnt += pending_results.size();
      $display("%0d results never arrived", pending_results.size());
    end
    $display("Ran %0d adds, %0d deletes, %0d checks, %0d ignored-action items",
             n_add, n_del, n_check, n_ignored);
    $display("Saw %0d check hits, %0d duplicates, %0d full, %0d bad length, %0d not found",
             n_hits, n_dup, n_full, n_bad_len, n_missing);
    if (error_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
